// ===== hdl/rhsv_pkg.sv =====
// Shared types and constants for the 8-bit RGB to HSV pixel pipeline.
// No dependencies; every other file in hdl/ imports this package.
package rhsv_pkg;

   // channel and result width
   localparam int CHAN_W     = 8;
   // restoring-division steps: saturation quotient is 8 bits, hue quotient 6 bits
   localparam int SAT_STEPS  = 8;
   localparam int HUE_STEPS  = 6;
   localparam int SAT_PROD_W = 2 * CHAN_W;
   localparam int HUE_PROD_W = CHAN_W + HUE_STEPS;

   // scale constants of the conversion
   localparam int HSV_FULL     = 255;
   localparam int HSV_STEP     = 43;
   localparam int HSV_GREEN_AT = 85;
   localparam int HSV_BLUE_AT  = 171;

   // word carried through the divider stages
   typedef struct packed {
      logic [CHAN_W-1:0]    bright;   // max channel, saturation divisor
      logic [CHAN_W-1:0]    span;     // max - min, hue divisor
      logic                 neg;      // hue difference is negative
      logic [CHAN_W-1:0]    base;     // sector offset
      logic [CHAN_W-1:0]    sat_rem;  // partial remainder, saturation
      logic [SAT_STEPS-1:0] sat_sh;   // dividend bits out, quotient bits in
      logic [CHAN_W-1:0]    hue_rem;  // partial remainder, hue
      logic [HUE_STEPS-1:0] hue_sh;   // dividend bits out, quotient bits in
   } div_type;

endpackage

// ===== hdl/rhsv_front.sv =====
// Front end of the HSV pipeline: max/min and sector pick, then range,
// hue difference and scaled dividends. Two register stages. Uses rhsv_pkg.
module rhsv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rhsv_pkg::CHAN_W-1:0]   in_blue,
   input  logic [rhsv_pkg::CHAN_W-1:0]   in_green,
   input  logic [rhsv_pkg::CHAN_W-1:0]   in_red,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rhsv_pkg::div_type             out_word
);
   import rhsv_pkg::*;

   localparam logic [1:0] SEC_RED   = 2'd0;
   localparam logic [1:0] SEC_GREEN = 2'd1;
   localparam logic [1:0] SEC_BLUE  = 2'd2;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] hi;
      logic [CHAN_W-1:0] lo;
      logic [1:0]        sector;
   } pick_type;

   logic     s0_valid_ff, s0_valid_in;
   pick_type s0_word_ff, s0_word_in;
   logic     s0_ready;
   logic     s1_valid_ff, s1_valid_in;
   div_type  s1_word_ff, s1_word_in;
   logic     s1_ready;

   // stage 0: largest, smallest, and which channel wins (red first, then green)
   always_comb begin
      logic [CHAN_W-1:0] mx_rg;
      logic [CHAN_W-1:0] mn_rg;
      mx_rg = (in_red > in_green) ? in_red : in_green;
      mn_rg = (in_red < in_green) ? in_red : in_green;
      s0_word_in.red   = in_red;
      s0_word_in.green = in_green;
      s0_word_in.blue  = in_blue;
      s0_word_in.hi    = (in_blue > mx_rg) ? in_blue : mx_rg;
      s0_word_in.lo    = (in_blue < mn_rg) ? in_blue : mn_rg;
      if (s0_word_in.hi == in_red) begin
         s0_word_in.sector = SEC_RED;
      end else if (s0_word_in.hi == in_green) begin
         s0_word_in.sector = SEC_GREEN;
      end else begin
         s0_word_in.sector = SEC_BLUE;
      end
   end

   assign s0_ready    = !s0_valid_ff || s1_ready;
   assign s0_valid_in = s0_ready ? in_valid : s0_valid_ff;
   assign in_ready    = s0_ready;

   // stage 1: range, signed channel difference, dividends and first remainders
   always_comb begin
      logic [CHAN_W:0]         diff;
      logic [CHAN_W:0]         diff_neg;
      logic [CHAN_W-1:0]       span;
      logic [CHAN_W-1:0]       mag;
      logic [SAT_PROD_W-1:0]   sat_prod;
      logic [HUE_PROD_W-1:0]   hue_prod;
      span = s0_word_ff.hi - s0_word_ff.lo;
      case (s0_word_ff.sector)
         SEC_RED: begin
            diff = {1'b0, s0_word_ff.green} - {1'b0, s0_word_ff.blue};
            s1_word_in.base = '0;
         end
         SEC_GREEN: begin
            diff = {1'b0, s0_word_ff.blue} - {1'b0, s0_word_ff.red};
            s1_word_in.base = CHAN_W'(HSV_GREEN_AT);
         end
         default: begin
            diff = {1'b0, s0_word_ff.red} - {1'b0, s0_word_ff.green};
            s1_word_in.base = CHAN_W'(HSV_BLUE_AT);
         end
      endcase
      diff_neg = '0 - diff;
      mag      = diff[CHAN_W] ? diff_neg[CHAN_W-1:0] : diff[CHAN_W-1:0];
      sat_prod = SAT_PROD_W'({{(SAT_PROD_W-CHAN_W){1'b0}}, span}
                             * SAT_PROD_W'(HSV_FULL));
      hue_prod = HUE_PROD_W'({{(HUE_PROD_W-CHAN_W){1'b0}}, mag}
                             * HUE_PROD_W'(HSV_STEP));
      s1_word_in.bright  = s0_word_ff.hi;
      s1_word_in.span    = span;
      s1_word_in.neg     = diff[CHAN_W];
      // upper dividend halves are already below the divisor
      s1_word_in.sat_rem = sat_prod[SAT_PROD_W-1:SAT_STEPS];
      s1_word_in.sat_sh  = sat_prod[SAT_STEPS-1:0];
      s1_word_in.hue_rem = hue_prod[HUE_PROD_W-1:HUE_STEPS];
      s1_word_in.hue_sh  = hue_prod[HUE_STEPS-1:0];
   end

   assign s1_ready    = !s1_valid_ff || out_ready;
   assign s1_valid_in = s1_ready ? s0_valid_ff : s1_valid_ff;

   // advance both stages when the next one has room
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && in_valid) begin
         s0_word_ff <= s0_word_in;
      end
      if (s1_ready && s0_valid_ff) begin
         s1_word_ff <= s1_word_in;
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_word  = s1_word_ff;

endmodule

// ===== hdl/rhsv_div_stage.sv =====
// One registered restoring-division step for saturation and, in the first
// stages, hue. Uses rhsv_pkg for the word type and step counts.
module rhsv_div_stage #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rhsv_pkg::div_type in_word,
   output logic              out_valid,
   input  logic              out_ready,
   output rhsv_pkg::div_type out_word
);
   import rhsv_pkg::*;

   localparam bit HUE_ON = (STEP < HUE_STEPS);

   logic    valid_ff, valid_in;
   div_type word_ff, word_in;

   // shift in the next dividend bit, subtract the divisor where it fits
   always_comb begin
      logic [CHAN_W:0] sat_r2;
      logic [CHAN_W:0] sat_diff;
      logic            sat_go;
      logic [CHAN_W:0] hue_r2;
      logic [CHAN_W:0] hue_diff;
      logic            hue_go;
      word_in  = in_word;
      sat_r2   = {in_word.sat_rem, in_word.sat_sh[SAT_STEPS-1]};
      sat_diff = sat_r2 - {1'b0, in_word.bright};
      sat_go   = (sat_r2 >= {1'b0, in_word.bright});
      word_in.sat_rem = sat_go ? sat_diff[CHAN_W-1:0] : sat_r2[CHAN_W-1:0];
      word_in.sat_sh  = {in_word.sat_sh[SAT_STEPS-2:0], sat_go};
      hue_r2   = {in_word.hue_rem, in_word.hue_sh[HUE_STEPS-1]};
      hue_diff = hue_r2 - {1'b0, in_word.span};
      hue_go   = (hue_r2 >= {1'b0, in_word.span});
      if (HUE_ON) begin
         word_in.hue_rem = hue_go ? hue_diff[CHAN_W-1:0] : hue_r2[CHAN_W-1:0];
         word_in.hue_sh  = {in_word.hue_sh[HUE_STEPS-2:0], hue_go};
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the word while stalled
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ===== hdl/rhsv_back.sv =====
// Output stage of the HSV pipeline: sign and sector offset for hue, grey and
// black override, result register. Uses rhsv_pkg.
module rhsv_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rhsv_pkg::div_type             in_word,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [rhsv_pkg::CHAN_W-1:0]   out_hue,
   output logic [rhsv_pkg::CHAN_W-1:0]   out_saturation,
   output logic [rhsv_pkg::CHAN_W-1:0]   out_brightness
);
   import rhsv_pkg::*;

   logic              valid_ff, valid_in;
   logic [CHAN_W-1:0] hue_ff, hue_in;
   logic [CHAN_W-1:0] sat_ff, sat_in;
   logic [CHAN_W-1:0] bright_ff;

   // apply the sign to the hue quotient, add the offset, wrap to 8 bits
   always_comb begin
      logic [CHAN_W-1:0] q_ext;
      q_ext = {{(CHAN_W-HUE_STEPS){1'b0}}, in_word.hue_sh};
      if (in_word.span == '0) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = in_word.neg ? (in_word.base - q_ext) : (in_word.base + q_ext);
         sat_in = in_word.sat_sh;
      end
   end

   assign in_ready = !valid_ff || !out_stall;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= in_word.bright;
      end
   end

   assign out_valid      = valid_ff;
   assign out_hue        = hue_ff;
   assign out_saturation = sat_ff;
   assign out_brightness = bright_ff;

endmodule

// ===== hdl/rgb_to_hsv_8bit_pixel.sv =====
// Top level of the 8-bit RGB to HSV pixel converter.
// Depends on rhsv_pkg, rhsv_front, rhsv_div_stage and rhsv_back.
//
// Usage:
//   Input word: req_blue, req_green, req_red, taken at a clock edge where
//   req_valid is high and req_stall is low.
//   Result word: rsp_hue, rsp_saturation, rsp_brightness, taken at a clock
//   edge where rsp_valid is high and rsp_stall is low. Every pixel gives
//   exactly one result, in order.
//   Path from acceptance to rsp_valid: two front stages (max/min, then
//   range and dividends), eight one-bit restoring-division stages (the
//   saturation quotient has 8 bits; the 6-bit hue quotient runs alongside
//   in the first six), one output stage.
//   Throughput: one pixel per cycle while rsp_stall does not back it up.
//   Stall: each stage holds its word while the one after it is full and
//   stalled; empty stages still fill, so req_stall rises only when all
//   eleven stages hold a word and rsp_stall is high. Nothing is lost or
//   repeated.
//   Reset: synchronous, active high; clears every stage valid, so the
//   pipeline comes up empty and ready. No configuration.
module rgb_to_hsv_8bit_pixel (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rhsv_pkg::CHAN_W-1:0]   req_blue,
   input  logic [rhsv_pkg::CHAN_W-1:0]   req_green,
   input  logic [rhsv_pkg::CHAN_W-1:0]   req_red,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rhsv_pkg::CHAN_W-1:0]   rsp_hue,
   output logic [rhsv_pkg::CHAN_W-1:0]   rsp_saturation,
   output logic [rhsv_pkg::CHAN_W-1:0]   rsp_brightness
);
   import rhsv_pkg::*;

   logic    front_ready;
   logic    stage_valid [0:SAT_STEPS];
   logic    stage_ready [0:SAT_STEPS];
   div_type stage_word  [0:SAT_STEPS];

   // front end: max/min and dividends
   rhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_blue   (req_blue),
      .in_green  (req_green),
      .in_red    (req_red),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_word  (stage_word[0])
   );

   assign req_stall = !front_ready;

   // divider chain, one quotient bit per stage
   for (genvar k = 0; k < SAT_STEPS; k++) begin : g_div
      rhsv_div_stage #(
         .STEP (k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_word   (stage_word[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_word  (stage_word[k+1])
      );
   end

   // final assembly and result register
   rhsv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stage_valid[SAT_STEPS]),
      .in_ready       (stage_ready[SAT_STEPS]),
      .in_word        (stage_word[SAT_STEPS]),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_hue        (rsp_hue),
      .out_saturation (rsp_saturation),
      .out_brightness (rsp_brightness)
   );

   // a grey pixel has no hue
   a_grey_no_hue : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_saturation == '0) |-> (rsp_hue == '0))
      else $error("nonzero hue on a pixel with zero saturation");

   // a black pixel has no saturation
   a_black_no_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_brightness == '0) |-> (rsp_saturation == '0))
      else $error("nonzero saturation on a black pixel");

   // the input only backs up once the whole pipeline is full and stalled
   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && stage_valid[0]))
      else $error("input stalled while the pipeline has room");

endmodule
